/* design/gtq_pkg.sv */
package gtq_pkg;

  // Parameter defaults
  localparam int TEAM_COUNT_DEF   = 16;
  localparam int TEAM_DEPTH_DEF   = 64;
  localparam int ELEMENT_BITS_DEF = 20;

  // Fixed field widths of the stream payload
  localparam int ELEMENT_W  = 20;
  localparam int TEAM_ID_W  = 4;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int OP_W       = 3;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Classified commands handed from front to back
  localparam logic [OP_W-1:0] OP_ENQ = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 3'd1;
  localparam logic [OP_W-1:0] OP_CLR = 3'd2;
  localparam logic [OP_W-1:0] OP_NOP = 3'd3;
  localparam logic [OP_W-1:0] OP_REJ = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ELEMENT_W-1:0] element;
    logic [TEAM_ID_W-1:0] team;
  } cmd_t;

  typedef struct packed {
    logic [ELEMENT_W-1:0] element;
    logic                 valid;
    logic [STATUS_W-1:0]  status;
  } result_t;

endpackage

/* design/grouped_team_queue.sv */
// Steps: an enqueue passes S_ENQ and S_RESP, a dequeue S_DEQ_RING, S_DEQ_REC, S_DEQ_MEM
//   and S_RESP, a clear sweeps every team record in S_CLR before S_RESP; rejects, no-ops
//   and dequeues while empty go straight to S_RESP. The back-end sequencer, with its
//   registered memory reads, takes one command at a time; the front queue holds up to two
//   further beats meanwhile. Reset: synchronous, active low; the team records are then
//   swept, one per cycle, while in_tready stays low.
module grouped_team_queue #(
  parameter int TEAM_COUNT   = gtq_pkg::TEAM_COUNT_DEF,
  parameter int TEAM_DEPTH   = gtq_pkg::TEAM_DEPTH_DEF,
  parameter int ELEMENT_BITS = gtq_pkg::ELEMENT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gtq_pkg::IN_DATA_W-1:0]    in_tdata,   // element [19:0], team_id [23:20]
  input  logic [gtq_pkg::MODE_W-1:0]       in_tuser,   // mode [1:0]
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gtq_pkg::OUT_DATA_W-1:0]   out_tdata,  // out_element [19:0], zero [23:20]
  output logic [gtq_pkg::OUT_USER_W-1:0]   out_tuser   // out_valid [0], status [2:1]
);

  logic             init_busy;
  logic             cmd_valid;
  logic             cmd_ready;
  gtq_pkg::cmd_t    cmd;
  gtq_pkg::result_t out_res;

  // Front: take beats, sort them into commands and hold them in a two-entry queue.
  // Enqueues for a team number of TEAM_COUNT or more become rejects here.
  gtq_front #(
    .TEAM_COUNT (TEAM_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tuser),
    .in_element (in_tdata[gtq_pkg::ELEMENT_W-1:0]),
    .in_team_id (in_tdata[gtq_pkg::ELEMENT_W+gtq_pkg::TEAM_ID_W-1:gtq_pkg::ELEMENT_W]),
    .init_busy  (init_busy),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // Back: run one command at a time against the team records, the team order ring and
  // the element store, then hold the result in the output register until it is taken.
  gtq_back #(
    .TEAM_COUNT   (TEAM_COUNT),
    .TEAM_DEPTH   (TEAM_DEPTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .init_busy (init_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result beat
  assign out_tdata = gtq_pkg::OUT_DATA_W'(out_res.element);
  assign out_tuser = {out_res.status, out_res.valid};

endmodule

/* design/gtq_front.sv */
module gtq_front #(
  parameter int TEAM_COUNT = gtq_pkg::TEAM_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gtq_pkg::MODE_W-1:0]     in_mode,
  input  logic [gtq_pkg::ELEMENT_W-1:0]  in_element,
  input  logic [gtq_pkg::TEAM_ID_W-1:0]  in_team_id,
  input  logic                           init_busy,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output gtq_pkg::cmd_t                  cmd
);

  gtq_pkg::cmd_t   q_r [2];
  logic            wr_r, wr_nxt;
  logic            rd_r, rd_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, pop;
  logic [31:0]     team_ext;
  gtq_pkg::cmd_t   cls;

  assign team_ext = 32'(in_team_id);

  // Classify the beat
  always_comb begin
    cls.element = in_element;
    cls.team    = in_team_id;
    case (in_mode)
      gtq_pkg::MODE_ENQ: cls.op = (team_ext < TEAM_COUNT) ? gtq_pkg::OP_ENQ : gtq_pkg::OP_REJ;
      gtq_pkg::MODE_DEQ: cls.op = gtq_pkg::OP_DEQ;
      gtq_pkg::MODE_CLR: cls.op = gtq_pkg::OP_CLR;
      default:           cls.op = gtq_pkg::OP_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2) && !init_busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= cls;
    end
  end

endmodule

/* design/gtq_back.sv */
module gtq_back #(
  parameter int TEAM_COUNT   = gtq_pkg::TEAM_COUNT_DEF,
  parameter int TEAM_DEPTH   = gtq_pkg::TEAM_DEPTH_DEF,
  parameter int ELEMENT_BITS = gtq_pkg::ELEMENT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  gtq_pkg::cmd_t    cmd,
  output logic             init_busy,
  output logic             out_valid,
  input  logic             out_ready,
  output gtq_pkg::result_t out_res
);

  localparam int TW        = $clog2(TEAM_COUNT);
  localparam int PW        = $clog2(TEAM_DEPTH);
  localparam int FW        = $clog2(TEAM_DEPTH + 1);
  localparam int SW        = FW + 1;
  localparam int OFW       = $clog2(TEAM_COUNT + 1);
  localparam int DEPTH_ALL = TEAM_COUNT * TEAM_DEPTH;
  localparam int AW        = $clog2(DEPTH_ALL);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_ENQ      = 3'd2;
  localparam logic [2:0] S_DEQ_RING = 3'd3;
  localparam logic [2:0] S_DEQ_REC  = 3'd4;
  localparam logic [2:0] S_DEQ_MEM  = 3'd5;
  localparam logic [2:0] S_CLR      = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  // Memories
  logic [PW-1:0]           ptr_mem  [TEAM_COUNT];
  logic [FW-1:0]           fill_mem [TEAM_COUNT];
  logic [TW-1:0]           ring_mem [TEAM_COUNT];
  logic [ELEMENT_BITS-1:0] elem_mem [DEPTH_ALL];

  logic [PW-1:0]           ptr_rd_r;
  logic [FW-1:0]           fill_rd_r;
  logic [TW-1:0]           ring_rd_r;
  logic [ELEMENT_BITS-1:0] elem_rd_r;

  // Control and payload registers
  logic [2:0]        state_r, state_nxt;
  logic [TW-1:0]     sweep_r, sweep_nxt;
  logic [TW-1:0]     front_r, front_nxt;
  logic [TW-1:0]     back_r, back_nxt;
  logic [OFW-1:0]    ofill_r, ofill_nxt;
  logic              out_valid_r, out_valid_nxt;
  gtq_pkg::cmd_t     cmd_r, cmd_nxt;
  logic [TW-1:0]     deq_team_r, deq_team_nxt;
  gtq_pkg::result_t  res_r, res_nxt;
  gtq_pkg::result_t  out_res_r, out_res_nxt;

  // Datapath
  logic [31:0]             cmd_team_ext, cmd_r_team_ext, elem_in_ext, elem_rd_ext;
  logic [TW-1:0]           team_in, team_cur;
  logic                    enq_full;
  logic [SW-1:0]           slot_sum, slot_w;
  logic [PW-1:0]           slot_idx, ptr_inc;
  logic [TW-1:0]           base_team;
  logic [PW-1:0]           addr_off;
  logic [AW-1:0]           elem_addr;
  logic [TW-1:0]           rec_raddr, rec_waddr;
  logic                    rec_we;
  logic [PW-1:0]           rec_wptr;
  logic [FW-1:0]           rec_wfill;
  logic                    ring_we;
  logic                    elem_we;
  logic [ELEMENT_BITS-1:0] elem_wdata;
  logic [TW-1:0]           front_inc, back_inc;
  logic                    sweep_last;

  assign cmd_team_ext   = 32'(cmd.team);
  assign cmd_r_team_ext = 32'(cmd_r.team);
  assign team_in        = cmd_team_ext[TW-1:0];
  assign team_cur       = cmd_r_team_ext[TW-1:0];
  assign elem_in_ext    = 32'(cmd_r.element);
  assign elem_wdata     = elem_in_ext[ELEMENT_BITS-1:0];
  assign elem_rd_ext    = 32'(elem_rd_r);

  assign enq_full = (fill_rd_r == FW'(TEAM_DEPTH));
  assign slot_sum = SW'(ptr_rd_r) + SW'(fill_rd_r);
  assign slot_w   = (slot_sum >= SW'(TEAM_DEPTH)) ? slot_sum - SW'(TEAM_DEPTH) : slot_sum;
  assign slot_idx = slot_w[PW-1:0];
  assign ptr_inc  = (ptr_rd_r == PW'(TEAM_DEPTH - 1)) ? '0 : ptr_rd_r + PW'(1);

  // One address path serves the enqueue write and the dequeue read
  assign base_team = (state_r == S_ENQ) ? team_cur : deq_team_r;
  assign addr_off  = (state_r == S_ENQ) ? slot_idx : ptr_rd_r;
  assign elem_addr = AW'(base_team) * AW'(TEAM_DEPTH) + AW'(addr_off);

  assign front_inc  = (front_r == TW'(TEAM_COUNT - 1)) ? '0 : front_r + TW'(1);
  assign back_inc   = (back_r == TW'(TEAM_COUNT - 1)) ? '0 : back_r + TW'(1);
  assign sweep_last = (sweep_r == TW'(TEAM_COUNT - 1));

  assign rec_raddr = (state_r == S_DEQ_RING) ? ring_rd_r : team_in;
  assign elem_we   = (state_r == S_ENQ) && !enq_full;
  assign ring_we   = elem_we && (fill_rd_r == '0);

  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = sweep_r;
    rec_wptr  = '0;
    rec_wfill = '0;
    case (state_r)
      S_INIT, S_CLR: begin
        rec_we = 1'b1;
      end
      S_ENQ: begin
        rec_we    = !enq_full;
        rec_waddr = team_cur;
        rec_wptr  = ptr_rd_r;
        rec_wfill = fill_rd_r + FW'(1);
      end
      S_DEQ_REC: begin
        rec_we    = (fill_rd_r != '0);
        rec_waddr = deq_team_r;
        rec_wptr  = ptr_inc;
        rec_wfill = fill_rd_r - FW'(1);
      end
      default: begin
        rec_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      ptr_mem[rec_waddr]  <= rec_wptr;
      fill_mem[rec_waddr] <= rec_wfill;
    end
    ptr_rd_r  <= ptr_mem[rec_raddr];
    fill_rd_r <= fill_mem[rec_raddr];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[back_r] <= team_cur;
    end
    ring_rd_r <= ring_mem[front_r];
  end

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_addr] <= elem_wdata;
    end
    elem_rd_r <= elem_mem[elem_addr];
  end

  assign cmd_ready = (state_r == S_IDLE);
  assign init_busy = (state_r == S_INIT);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    ofill_nxt     = ofill_r;
    cmd_nxt       = cmd_r;
    deq_team_nxt  = deq_team_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_INIT: begin
        sweep_nxt = sweep_r + TW'(1);
        if (sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd;
          res_nxt = '{element: '0, valid: 1'b0, status: gtq_pkg::STATUS_OK};
          case (cmd.op)
            gtq_pkg::OP_ENQ: begin
              state_nxt = S_ENQ;
            end
            gtq_pkg::OP_DEQ: begin
              if (ofill_r == '0) begin
                res_nxt.status = gtq_pkg::STATUS_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_DEQ_RING;
              end
            end
            gtq_pkg::OP_CLR: begin
              sweep_nxt = '0;
              front_nxt = '0;
              back_nxt  = '0;
              ofill_nxt = '0;
              state_nxt = S_CLR;
            end
            gtq_pkg::OP_REJ: begin
              res_nxt.status = gtq_pkg::STATUS_FULL;
              state_nxt      = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_ENQ: begin
        if (enq_full) begin
          res_nxt.status = gtq_pkg::STATUS_FULL;
        end else if (fill_rd_r == '0) begin
          back_nxt  = back_inc;
          ofill_nxt = ofill_r + OFW'(1);
        end
        state_nxt = S_RESP;
      end
      S_DEQ_RING: begin
        deq_team_nxt = ring_rd_r;
        state_nxt    = S_DEQ_REC;
      end
      S_DEQ_REC: begin
        if (fill_rd_r == '0) begin
          res_nxt.status = gtq_pkg::STATUS_EMPTY;
          state_nxt      = S_RESP;
        end else begin
          if (fill_rd_r == FW'(1)) begin
            front_nxt = front_inc;
            ofill_nxt = ofill_r - OFW'(1);
          end
          state_nxt = S_DEQ_MEM;
        end
      end
      S_DEQ_MEM: begin
        res_nxt.element = elem_rd_ext[gtq_pkg::ELEMENT_W-1:0];
        res_nxt.valid   = 1'b1;
        state_nxt       = S_RESP;
      end
      S_CLR: begin
        sweep_nxt = sweep_r + TW'(1);
        if (sweep_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      front_r     <= '0;
      back_r      <= '0;
      ofill_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      ofill_r     <= ofill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    deq_team_r <= deq_team_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
  end

  a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ofill_r <= OFW'(TEAM_COUNT))
    else $error("team order count exceeds team count");

  a_order_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ofill_r == '0) |-> (front_r == back_r))
    else $error("empty team order with unequal ring pointers");

  a_front_team_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ_REC) |-> (fill_rd_r != '0))
    else $error("front team of the order has an empty FIFO");

  a_ring_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENQ && fill_rd_r == '0) |-> (ofill_r < OFW'(TEAM_COUNT)))
    else $error("new team joins a full order ring");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RESP))
    else $error("result presented outside the response step");

endmodule
